// File: src/rfc_pkg.sv
// rfc_pkg: shared types and constants for the record FIFO with cancel.
// No dependencies; imported by rfc_cell and record_fifo_with_cancel.
`default_nettype none

package rfc_pkg;

    // Number of record slots in the cell ring (2 .. 63; fill_count is 6 bits)
    localparam int RECORD_SLOTS = 32;
    // Count needs to hold RECORD_SLOTS itself
    localparam int CNT_W        = $clog2(RECORD_SLOTS + 1);
    localparam int REC_W        = 64;
    localparam int BYTE_W       = 8;
    localparam int FILL_W       = 6;

    typedef logic [REC_W-1:0]  record_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic REG_EMPTY_CODE = 1'b0;
    localparam logic REG_LOCAL_CODE = 1'b1;

    localparam byte_t EMPTY_CODE_RST = 8'd0;
    localparam byte_t LOCAL_CODE_RST = 8'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        mode_t   mode;
        record_t push_record;
        byte_t   cancel_id_low;
        byte_t   cancel_id_high;
    } rfc_in_t;

    typedef struct packed {
        record_t           pop_record;
        logic              was_empty;
        logic              dropped_oldest;
        logic [FILL_W-1:0] fill_count;
    } rfc_out_t;

endpackage

`default_nettype wire

// File: src/record_fifo_with_cancel.sv
// record_fifo_with_cancel: top level, control sequencer and ring of rfc_cell.
// Depends on rfc_pkg and rfc_cell.
//
// in_valid / in_stall / in_data take one operation item: push, pop, cancel
// by id or the unused mode (no operation). out_valid / out_stall / out_data
// return exactly one result item per input item, in order. cfg_we /
// cfg_index / cfg_data write the empty code (index 0) and local code
// (index 1); write only while idle.
//
// Records sit in a ring of RECORD_SLOTS cells, head in cell 0 at rest. An
// operation turns the ring once, one cell per cycle; the record leaving cell
// 0 passes the wrap logic (push insert, cancel rewrite of byte 0). Pop and
// push into a full queue take one extra step, which retires the old head.
//
// From accept to result, push and cancel take the ring turn, pop and push when
// full the extra step too, empty pop and unused mode go straight to finish.
// in_stall is high while an item is worked on, so no new item is taken
// until it is done. A finished item waits while out_stall holds the result
// register. rst_n clears count, control state and codes, not the record cells.
`default_nettype none

module record_fifo_with_cancel (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // configuration
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire rfc_pkg::byte_t   cfg_data,
    // input items
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire rfc_pkg::rfc_in_t in_data,
    // result items
    output logic                  out_valid,
    input  wire logic             out_stall,
    output rfc_pkg::rfc_out_t     out_data
);
    import rfc_pkg::*;

    localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(RECORD_SLOTS);
    localparam logic [CNT_W-1:0] SLOT_LAST  = CNT_W'(RECORD_SLOTS - 1);

    // Control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] last_reg, last_next;
    logic             out_valid_reg, out_valid_next;

    // Latched operation
    mode_t            op_reg;
    record_t          rec_reg;
    byte_t            idl_reg, idh_reg;
    logic [CNT_W-1:0] cnt_op_reg;
    logic             full_op_reg;
    logic             was_empty_reg;
    logic             dropped_reg;
    record_t          head_reg;
    rfc_out_t         out_data_reg, out_data_next;

    byte_t            empty_code_reg, local_code_reg;

    logic             in_acc;
    logic             is_full, is_empty;
    logic             shift;
    logic             out_load;
    logic             cancel_hit;
    logic [CNT_W-1:0] push_slot;
    record_t          wrap_val;
    record_t          cell_q [RECORD_SLOTS];

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign is_full   = (count_reg == SLOT_COUNT);
    assign is_empty  = (count_reg == '0);
    assign shift     = (state_reg == ST_RUN);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_code_reg <= EMPTY_CODE_RST;
            local_code_reg <= LOCAL_CODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EMPTY_CODE: empty_code_reg <= cfg_data;
                REG_LOCAL_CODE: local_code_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Wrap logic: what re-enters the ring at the far end
    // ---------------------------------------------------------------
    // Slot for a push: after the tail, or the old head slot when full
    assign push_slot  = full_op_reg ? '0 : cnt_op_reg;
    assign cancel_hit = (step_reg < cnt_op_reg)
                     && (cell_q[0][7:0]   == local_code_reg)
                     && (cell_q[0][15:8]  == idl_reg)
                     && (cell_q[0][23:16] == idh_reg);

    always_comb
    begin
        wrap_val = cell_q[0];
        case (op_reg)
            MODE_PUSH:
            begin
                if (step_reg == push_slot)
                begin
                    wrap_val = rec_reg;
                end
            end
            MODE_CANCEL:
            begin
                if (cancel_hit)
                begin
                    wrap_val = {cell_q[0][REC_W-1:BYTE_W], empty_code_reg};
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Ring of cells; cell 0 holds the head at rest
    // ---------------------------------------------------------------
    for (genvar i = 0; i < RECORD_SLOTS; i++)
    begin : g_cell
        record_t d_in;
        if (i == RECORD_SLOTS - 1)
        begin : g_tail
            assign d_in = wrap_val;
        end
        else
        begin : g_mid
            assign d_in = cell_q[i+1];
        end

        rfc_cell u_cell (
            .clk   (clk),
            .shift (shift),
            .d     (d_in),
            .q     (cell_q[i])
        );
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    step_next = '0;
                    case (in_data.mode)
                        MODE_PUSH:
                        begin
                            state_next = ST_RUN;
                            if (is_full)
                            begin
                                last_next = SLOT_COUNT;
                            end
                            else
                            begin
                                last_next  = SLOT_LAST;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            if (is_empty)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_RUN;
                                last_next  = SLOT_COUNT;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        MODE_CANCEL:
                        begin
                            state_next = ST_RUN;
                            last_next  = SLOT_LAST;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == last_reg)
                begin
                    step_next  = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data_next                = '0;
        out_data_next.was_empty      = was_empty_reg;
        out_data_next.dropped_oldest = dropped_reg;
        out_data_next.fill_count     = FILL_W'(count_reg);
        if (op_reg == MODE_POP)
        begin
            if (was_empty_reg)
            begin
                out_data_next.pop_record = {{(REC_W-BYTE_W){1'b0}}, empty_code_reg};
            end
            else
            begin
                out_data_next.pop_record = head_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Operation payload, latched at accept
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg        <= in_data.mode;
            rec_reg       <= in_data.push_record;
            idl_reg       <= in_data.cancel_id_low;
            idh_reg       <= in_data.cancel_id_high;
            cnt_op_reg    <= count_reg;
            full_op_reg   <= is_full;
            was_empty_reg <= (in_data.mode == MODE_POP) && is_empty;
            dropped_reg   <= (in_data.mode == MODE_PUSH) && is_full;
        end
        // Head leaves cell 0 on the first step
        if (shift && (step_reg == '0))
        begin
            head_reg <= cell_q[0];
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOT_COUNT)
        else $error("record count above slot count");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_data.mode == MODE_PUSH) |=> count_reg != '0)
        else $error("queue empty after push");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> step_reg <= last_reg)
        else $error("ring step past last step");

endmodule

`default_nettype wire

// File: src/rfc_cell.sv
// rfc_cell: one record slot of the rotating ring.
// Depends on rfc_pkg for the record type.
`default_nettype none

module rfc_cell (
    input  wire logic            clk,
    input  wire logic            shift,
    input  wire rfc_pkg::record_t d,
    output rfc_pkg::record_t     q
);
    import rfc_pkg::*;

    record_t data_reg;

    // Payload only: no reset
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

`default_nettype wire

// File: tb/tb_record_fifo_with_cancel.sv
// tb_record_fifo_with_cancel: self-checking testbench for the record FIFO with cancel.
// Depends on rfc_pkg and record_fifo_with_cancel; predicts every result item in a
// small scoreboard class while plain tasks drive random traffic with gaps and stalls.
`default_nettype none

module tb_record_fifo_with_cancel;
    import rfc_pkg::*;

    localparam int     CLK_PERIOD    = 8;
    localparam int     RESET_CYCLES  = 11;
    // Slowest item is a pop or a push into a full queue: one full turn plus one step
    localparam int     ITEM_CYCLES   = RECORD_SLOTS + 3;
    // Long enough for the result register to fill and the input to stall
    localparam int     HOLD_CYCLES   = 400;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_ITEMS   = 140;
    localparam int     ID_POOL       = 4;
    localparam longint LIMIT_CYCLES  = 1_500_000;

    // ------------------------------------------------------------------
    // Scoreboard: a queue of held records plus the two code registers.
    // apply_item works out the result an accepted item must produce and
    // files it; check_result takes the oldest filed result and compares.
    // ------------------------------------------------------------------
    class record_queue_model;
        record_t  held_records[$];
        rfc_out_t pending_results[$];
        byte_t    empty_code;
        byte_t    local_code;
        int       errors;

        function new();
            empty_code = EMPTY_CODE_RST;
            local_code = LOCAL_CODE_RST;
            errors     = 0;
        endfunction

        function void set_code(logic index, byte_t value);
            if (index == REG_EMPTY_CODE)
                empty_code = value;
            else
                local_code = value;
        endfunction

        function void apply_item(rfc_in_t it);
            rfc_out_t res;
            record_t  rec;
            res = '0;
            case (it.mode)
                MODE_PUSH:
                begin
                    // full queue: oldest record goes first, count stays at the top
                    if (held_records.size() >= RECORD_SLOTS)
                    begin
                        void'(held_records.pop_front());
                        res.dropped_oldest = 1'b1;
                    end
                    held_records.push_back(it.push_record);
                end
                MODE_POP:
                begin
                    if (held_records.size() == 0)
                    begin
                        res.pop_record = record_t'(empty_code);
                        res.was_empty  = 1'b1;
                    end
                    else
                        res.pop_record = held_records.pop_front();
                end
                MODE_CANCEL:
                begin
                    // cancelled records keep their place, only byte 0 changes
                    for (int i = 0; i < held_records.size(); i++)
                    begin
                        rec = held_records[i];
                        if (rec[7:0] == local_code && rec[15:8] == it.cancel_id_low &&
                            rec[23:16] == it.cancel_id_high)
                        begin
                            rec[7:0]        = empty_code;
                            held_records[i] = rec;
                        end
                    end
                end
                default: ;
            endcase
            res.fill_count = FILL_W'(held_records.size());
            pending_results.push_back(res);
        endfunction

        function void check_result(rfc_out_t got);
            rfc_out_t want;
            if (pending_results.size() == 0)
            begin
                $error("result item with none outstanding: %h", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.pop_record !== want.pop_record)
            begin
                $error("pop_record: expected %h, got %h", want.pop_record, got.pop_record);
                errors++;
            end
            if (got.was_empty !== want.was_empty)
            begin
                $error("was_empty: expected %b, got %b", want.was_empty, got.was_empty);
                errors++;
            end
            if (got.dropped_oldest !== want.dropped_oldest)
            begin
                $error("dropped_oldest: expected %b, got %b",
                       want.dropped_oldest, got.dropped_oldest);
                errors++;
            end
            if (got.fill_count !== want.fill_count)
            begin
                $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------
    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    logic     cfg_index;
    byte_t    cfg_data;
    logic     in_valid;
    logic     in_stall;
    rfc_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    rfc_out_t out_data;

    record_fifo_with_cancel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    record_queue_model model = new();

    // quiet: neither side idles; hold_off_req: asks the receiver for a long stall
    bit    quiet        = 1'b0;
    bit    hold_off_req = 1'b0;
    // id pairs that pushed records carry, so that cancels find matches
    byte_t id_lo[ID_POOL];
    byte_t id_hi[ID_POOL];

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Inputs move on the falling edge, so the rising edge sees settled values
    // on both sides; accepted items and results are picked up here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                model.apply_item(in_data);
            if (out_valid && !out_stall)
                model.check_result(out_data);
        end
    end

    // Mostly no gap or a short one, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    function automatic rfc_in_t mk_item(mode_t m, record_t rec, byte_t lo, byte_t hi);
        rfc_in_t it;
        it.mode           = m;
        it.push_record    = rec;
        it.cancel_id_low  = lo;
        it.cancel_id_high = hi;
        return it;
    endfunction

    // Random item. Pushed records mostly look like local scene records with an
    // id from the pool; cancels mostly name a pool id, sometimes with a
    // mismatched high byte so that only part of the id agrees.
    function automatic rfc_in_t rand_item(int push_pct, int pop_pct);
        rfc_in_t it;
        int      roll;
        int      k;
        int      kind;
        it = mk_item(MODE_NOP, {$urandom, $urandom}, byte_t'($urandom), byte_t'($urandom));
        k    = $urandom_range(0, ID_POOL - 1);
        roll = $urandom_range(0, 99);
        if (roll < 3)
            it.mode = MODE_NOP;
        else if (roll < 3 + push_pct)
        begin
            it.mode = MODE_PUSH;
            kind    = $urandom_range(0, 9);
            if (kind < 8)
            begin
                it.push_record[7:0]   = (kind < 6) ? model.local_code : model.empty_code;
                it.push_record[15:8]  = id_lo[k];
                it.push_record[23:16] = id_hi[k];
            end
        end
        else if (roll < 3 + push_pct + pop_pct)
            it.mode = MODE_POP;
        else
        begin
            it.mode = MODE_CANCEL;
            if ($urandom_range(0, 99) < 85)
            begin
                it.cancel_id_low  = id_lo[k];
                it.cancel_id_high = id_hi[($urandom_range(0, 4) == 0) ?
                                          $urandom_range(0, ID_POOL - 1) : k];
            end
        end
        return it;
    endfunction

    // Offer one item from a falling edge and hold it until taken; valid stays
    // high into the next item unless a gap is drawn.
    task automatic send_item(input rfc_in_t it);
        int gap;
        in_data  = it;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop offering, let every expected result arrive, then allow one more
    // item time so the block is surely at rest
    task automatic wait_drained();
        in_valid = 1'b0;
        while (model.outstanding() != 0)
            @(posedge clk);
        repeat (ITEM_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Register write, only ever issued while the block is at rest
    task automatic write_reg(input logic idx, input byte_t value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        model.set_code(idx, value);
    endtask

    // Receiver: random stalls, plus one long hold-off on request, counted here
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                stall_left   = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall = 1'b0;
                if (!quiet && $urandom_range(0, 2) == 0)
                    stall_left = gap_len();
            end
        end
    end

    initial
    begin : stimulus
        rfc_in_t it;
        byte_t   e_code;
        byte_t   l_code;
        int      push_pct;
        int      pop_pct;
        int      sent;

        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_EMPTY_CODE;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, reset codes: empty 0, local 1.
        // Empty queue: pop, cancel and the unused mode.
        send_item(mk_item(MODE_POP, '0, 8'h00, 8'h00));
        send_item(mk_item(MODE_CANCEL, '0, 8'h00, 8'h00));
        send_item(mk_item(MODE_NOP, '1, 8'hFF, 8'hFF));
        // Extreme records, then local records around id 0x1234
        send_item(mk_item(MODE_PUSH, 64'h0, 8'h00, 8'h00));
        send_item(mk_item(MODE_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h00));
        send_item(mk_item(MODE_PUSH, 64'hA5A5_A5A5_A512_3401, 8'h00, 8'h00));
        send_item(mk_item(MODE_PUSH, 64'h0000_0000_0012_3401, 8'h00, 8'h00));
        send_item(mk_item(MODE_PUSH, 64'h0000_0000_0012_3501, 8'h00, 8'h00));
        send_item(mk_item(MODE_PUSH, 64'h0000_0000_0013_3401, 8'h00, 8'h00));
        send_item(mk_item(MODE_PUSH, 64'h0000_0000_0012_3402, 8'h00, 8'h00));
        // Hits two records; the repeat finds them already marked; all-ones id hits none
        send_item(mk_item(MODE_CANCEL, '0, 8'h34, 8'h12));
        send_item(mk_item(MODE_CANCEL, '0, 8'h34, 8'h12));
        send_item(mk_item(MODE_CANCEL, '1, 8'hFF, 8'hFF));
        // Pop everything back out, one more on the empty queue
        repeat (8) send_item(mk_item(MODE_POP, '0, 8'h00, 8'h00));
        send_item(mk_item(MODE_PUSH, {$urandom, $urandom}, 8'h00, 8'h00));
        send_item(mk_item(MODE_POP, '0, 8'h00, 8'h00));
        wait_drained();

        // Random part: each phase its own codes, id pool and operation mix
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       begin e_code = 8'hFF; l_code = 8'h00; end
                1:       begin e_code = 8'h00; l_code = 8'hFF; end
                2:       begin e_code = 8'hFF; l_code = 8'hFF; end
                3:       begin e_code = EMPTY_CODE_RST; l_code = LOCAL_CODE_RST; end
                5:       begin e_code = 8'h5A; l_code = 8'h5A; end
                default: begin e_code = byte_t'($urandom); l_code = byte_t'($urandom); end
            endcase
            write_reg(REG_EMPTY_CODE, e_code);
            write_reg(REG_LOCAL_CODE, l_code);
            for (int k = 0; k < ID_POOL; k++)
            begin
                id_lo[k] = byte_t'($urandom);
                id_hi[k] = byte_t'($urandom);
            end
            // push-heavy phases overrun the queue, pop-heavy ones empty it
            case (phase % 4)
                0:       begin push_pct = 60; pop_pct = 17; end
                1:       begin push_pct = 17; pop_pct = 60; end
                2:       begin push_pct = 40; pop_pct = 32; end
                default: begin push_pct = 42; pop_pct = 15; end
            endcase
            quiet = (phase == 3);

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // receiver holds off while items keep coming, so the input stalls
                if (phase == 1 && sent == 20)
                    hold_off_req = 1'b1;
                // sender pauses until every result is home
                if (phase == 5 && sent == 70)
                    wait_drained();
                it = rand_item(push_pct, pop_pct);
                send_item(it);
                if (it.mode != MODE_NOP)
                    sent++;
            end
            wait_drained();
        end
        quiet = 1'b0;

        if (model.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
